@@ rtl/euler_angle_rotation_3d_macros.svh @@
// Assertion macros for the Euler rotation block.
// Included by modules that check their own pipeline behavior.
`ifndef EULER_ANGLE_ROTATION_3D_MACROS_SVH
`define EULER_ANGLE_ROTATION_3D_MACROS_SVH
`ifndef SYNTH
`define EAR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define EAR_ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EAR_ASSERT(lbl, clk, rstn, prop, msg)
`define EAR_ASSERT_RST(lbl, clk, rstn, prop, msg)
`endif
`endif

@@ rtl/ear_pkg.sv @@
// Shared constants, types and helpers for the Euler rotation block.
// No dependencies.
`default_nettype none
package ear_pkg;
  localparam int unsigned AngW     = 17;
  localparam int unsigned VecW     = 32;
  localparam int unsigned ZW       = 34;   // Q30 radians incl. sign, with headroom
  localparam int unsigned CW       = 33;   // CORDIC x/y datapath, Q30
  localparam int unsigned AtanN    = 31;
  localparam logic signed [17:0] FullTurn    = 18'sd46080;
  localparam logic signed [17:0] HalfTurn    = 18'sd23040;
  localparam logic signed [17:0] QuarterTurn = 18'sd11520;
  localparam logic signed [35:0] RadPerUnit  = 36'sd9595049034;
  localparam logic signed [CW-1:0] GainQ30   = 33'sd652032874;

  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0: r = 34'sh03243F6A8;  5'd1: r = 34'sh01DAC6705;
      5'd2: r = 34'sh00FADBAFC;  5'd3: r = 34'sh007F56EA6;
      5'd4: r = 34'sh003FEAB76;  5'd5: r = 34'sh001FFD55B;
      5'd6: r = 34'sh000FFFAAA;  5'd7: r = 34'sh0007FFF55;
      5'd8: r = 34'sh0003FFFEA;  5'd9: r = 34'sh0001FFFFD;
      5'd10: r = 34'sh000FFFFF;  5'd11: r = 34'sh0007FFFF;
      5'd12: r = 34'sh0003FFFF;  5'd13: r = 34'sh0001FFFF;
      5'd14: r = 34'sh0000FFFF;  5'd15: r = 34'sh00007FFF;
      5'd16: r = 34'sh00003FFF;  5'd17: r = 34'sh00001FFF;
      5'd18: r = 34'sh00000FFF;  5'd19: r = 34'sh000007FF;
      5'd20: r = 34'sh000003FF;  5'd21: r = 34'sh000001FF;
      5'd22: r = 34'sh000000FF;  5'd23: r = 34'sh0000007F;
      5'd24: r = 34'sh0000003F;  5'd25: r = 34'sh0000001F;
      5'd26: r = 34'sh0000000F;  5'd27: r = 34'sh00000008;
      5'd28: r = 34'sh00000004;  5'd29: r = 34'sh00000002;
      5'd30: r = 34'sh00000001;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

@@ rtl/ear_sincos.sv @@
// Pipelined CORDIC sine/cosine of one angle in 1/128 degree units.
// Uses ear_pkg. Accepts one angle per cycle.
`default_nettype none
module ear_sincos #(
  parameter int unsigned CORDIC_STAGES  = 18,
  parameter int unsigned TRIG_FRAC_BITS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  input  wire logic signed [ear_pkg::AngW-1:0] angle_i,
  output logic                             valid_o,
  output logic signed [TRIG_FRAC_BITS+1:0] sin_o,
  output logic signed [TRIG_FRAC_BITS+1:0] cos_o
);
  localparam int unsigned CW = ear_pkg::CW;
  localparam int unsigned ZW = ear_pkg::ZW;
  localparam int unsigned TW = TRIG_FRAC_BITS + 2;
  localparam int unsigned RS = 30 - TRIG_FRAC_BITS;
  localparam int unsigned NS = (CORDIC_STAGES < ear_pkg::AtanN) ? CORDIC_STAGES
                                                                 : ear_pkg::AtanN;

  // stage A: range reduction into [-90, 90] degrees
  logic signed [17:0] a_w, r_w, f_w;
  logic               flip_w;
  logic signed [17:0] red_q;
  logic               flip_a_q, va_q;
  always_comb begin
    a_w = 18'(angle_i);
    r_w = a_w;
    if (a_w > ear_pkg::HalfTurn) r_w = a_w - ear_pkg::FullTurn;
    else if (a_w < -ear_pkg::HalfTurn) r_w = a_w + ear_pkg::FullTurn;
    f_w = r_w;
    flip_w = 1'b0;
    if (r_w > ear_pkg::QuarterTurn) begin
      f_w = r_w - ear_pkg::HalfTurn;
      flip_w = 1'b1;
    end else if (r_w < -ear_pkg::QuarterTurn) begin
      f_w = r_w + ear_pkg::HalfTurn;
      flip_w = 1'b1;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) va_q <= 1'b0;
    else va_q <= valid_i;
  end
  always_ff @(posedge clk_i) begin
    red_q <= f_w;
    flip_a_q <= flip_w;
  end

  // stage B: convert to Q30 radians
  logic signed [53:0] zp_w;
  logic signed [ZW-1:0] z0_q;
  logic flip_b_q, vb_q;
  assign zp_w = 54'(red_q) * 54'(ear_pkg::RadPerUnit) + 54'sd32768;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vb_q <= 1'b0;
    else vb_q <= va_q;
  end
  always_ff @(posedge clk_i) begin
    z0_q <= ZW'(zp_w >>> 16);
    flip_b_q <= flip_a_q;
  end

  // CORDIC rotation stages
  logic signed [CW-1:0] x_q [NS+1];
  logic signed [CW-1:0] y_q [NS+1];
  logic signed [ZW-1:0] z_q [NS+1];
  logic v_q [NS+1];
  logic f_q [NS+1];
  assign x_q[0] = ear_pkg::GainQ30;
  assign y_q[0] = '0;
  assign z_q[0] = z0_q;
  assign v_q[0] = vb_q;
  assign f_q[0] = flip_b_q;
  for (genvar i = 0; i < NS; i++) begin : g_st
    logic signed [CW-1:0] dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[i+1] <= 1'b0;
      else v_q[i+1] <= v_q[i];
    end
    always_ff @(posedge clk_i) begin
      f_q[i+1] <= f_q[i];
      if (!z_q[i][ZW-1]) begin
        x_q[i+1] <= x_q[i] - dx;
        y_q[i+1] <= y_q[i] + dy;
        z_q[i+1] <= z_q[i] - ear_pkg::atan_q30(5'(i));
      end else begin
        x_q[i+1] <= x_q[i] + dx;
        y_q[i+1] <= y_q[i] - dy;
        z_q[i+1] <= z_q[i] + ear_pkg::atan_q30(5'(i));
      end
    end
  end

  // output: round, clamp to +-1, apply half-turn flip
  function automatic logic signed [TW-1:0] rnd_clamp(input logic signed [CW-1:0] v,
                                                      input logic flip);
    logic signed [CW:0] t;
    logic signed [CW:0] one;
    logic signed [CW:0] r;
    t = (CW+1)'(v) + ((CW+1)'(1) <<< (RS - 1));
    t = t >>> RS;
    one = (CW+1)'(1) <<< TRIG_FRAC_BITS;
    r = t;
    if (t > one) r = one;
    else if (t < -one) r = -one;
    if (flip) r = -r;
    return TW'(r);
  endfunction
  logic vo_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vo_q <= 1'b0;
    else vo_q <= v_q[NS];
  end
  always_ff @(posedge clk_i) begin
    sin_o <= rnd_clamp(y_q[NS], f_q[NS]);
    cos_o <= rnd_clamp(x_q[NS], f_q[NS]);
  end
  assign valid_o = vo_q;
endmodule
`default_nettype wire

@@ rtl/euler_angle_rotation_3d.sv @@
// Top level: three CORDIC units, matrix build and matrix-vector product.
// Uses ear_pkg, ear_sincos and euler_angle_rotation_3d_macros.svh.
//
// channel  | direction | handshake      | payload
// command  | in        | start/busy     | vec_x/y/z_i, angle_x/y/z_i
// result   | out       | done_o strobe  | out_x/y/z_o, saturated_o
//
// One beat per cycle; a beat passes through the trig units (fold, radians,
// rotations, rounding), two matrix stages, a product and a sum stage.
// busy is held low: the pipeline never stops and results are not held.
// Reset (rst_ni low) clears all valid bits; data registers are not reset.
`default_nettype none
`include "euler_angle_rotation_3d_macros.svh"
module euler_angle_rotation_3d #(
  parameter int unsigned CORDIC_STAGES  = 18,
  parameter int unsigned TRIG_FRAC_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] vec_x_i,
  input  wire logic signed [31:0] vec_y_i,
  input  wire logic signed [31:0] vec_z_i,
  input  wire logic signed [16:0] angle_x_i,
  input  wire logic signed [16:0] angle_y_i,
  input  wire logic signed [16:0] angle_z_i,
  output logic                    done_o,
  output logic signed [31:0]      out_x_o,
  output logic signed [31:0]      out_y_o,
  output logic signed [31:0]      out_z_o,
  output logic                    saturated_o
);
  localparam int unsigned F  = TRIG_FRAC_BITS;
  localparam int unsigned TW = F + 2;
  localparam int unsigned PW = 2 * TW + 2;
  localparam int unsigned SL = CORDIC_STAGES + 3;  // sincos latency
  localparam int unsigned AW = 32 + TW + 3;

  assign busy = 1'b0;
  logic in_v;
  assign in_v = start & ~busy;

  // trig units
  logic signed [TW-1:0] sa, ca, sb, cb, sc, cc;
  logic vt, vt_y, vt_z;
  ear_sincos #(.CORDIC_STAGES(CORDIC_STAGES), .TRIG_FRAC_BITS(F)) u_sc_x (
    .clk_i, .rst_ni, .valid_i(in_v), .angle_i(angle_x_i),
    .valid_o(vt), .sin_o(sa), .cos_o(ca));
  ear_sincos #(.CORDIC_STAGES(CORDIC_STAGES), .TRIG_FRAC_BITS(F)) u_sc_y (
    .clk_i, .rst_ni, .valid_i(in_v), .angle_i(angle_y_i),
    .valid_o(vt_y), .sin_o(sb), .cos_o(cb));
  ear_sincos #(.CORDIC_STAGES(CORDIC_STAGES), .TRIG_FRAC_BITS(F)) u_sc_z (
    .clk_i, .rst_ni, .valid_i(in_v), .angle_i(angle_z_i),
    .valid_o(vt_z), .sin_o(sc), .cos_o(cc));

  // vector delay line matching the trig latency
  logic signed [31:0] vx_q [SL+1];
  logic signed [31:0] vy_q [SL+1];
  logic signed [31:0] vz_q [SL+1];
  assign vx_q[0] = vec_x_i;
  assign vy_q[0] = vec_y_i;
  assign vz_q[0] = vec_z_i;
  for (genvar i = 0; i < SL; i++) begin : g_dly
    always_ff @(posedge clk_i) begin
      vx_q[i+1] <= vx_q[i];
      vy_q[i+1] <= vy_q[i];
      vz_q[i+1] <= vz_q[i];
    end
  end

  function automatic logic signed [TW+1:0] mulr(input logic signed [TW+1:0] a,
                                                 input logic signed [TW+1:0] b);
    logic signed [PW-1:0] p;
    p = PW'(a) * PW'(b) + (PW'(1) <<< (F - 1));
    return (TW+2)'(p >>> F);
  endfunction
  function automatic logic signed [TW-1:0] clamp1(input logic signed [TW+2:0] v);
    logic signed [TW+2:0] one;
    one = (TW+3)'(1) <<< F;
    if (v > one) return TW'(one);
    if (v < -one) return TW'(-one);
    return TW'(v);
  endfunction

  // M1: pair products
  logic signed [TW+1:0] t_q, u_q, p00_q, pcs_q, psc_q, p10_q, pcc_q, psac_q;
  logic signed [TW+1:0] p21_q, p22_q, nsb_q;
  logic signed [TW+1:0] sc1_q, cc1_q;
  logic v1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else v1_q <= vt;
  end
  always_ff @(posedge clk_i) begin
    t_q   <= mulr((TW+2)'(sa), (TW+2)'(sb));
    u_q   <= mulr((TW+2)'(ca), (TW+2)'(sb));
    p00_q <= mulr((TW+2)'(cb), (TW+2)'(cc));
    pcs_q <= mulr((TW+2)'(ca), (TW+2)'(sc));
    psc_q <= mulr((TW+2)'(sa), (TW+2)'(sc));
    p10_q <= mulr((TW+2)'(cb), (TW+2)'(sc));
    pcc_q <= mulr((TW+2)'(ca), (TW+2)'(cc));
    psac_q <= mulr((TW+2)'(sa), (TW+2)'(cc));
    p21_q <= mulr((TW+2)'(sa), (TW+2)'(cb));
    p22_q <= mulr((TW+2)'(ca), (TW+2)'(cb));
    nsb_q <= -(TW+2)'(sb);
    sc1_q <= (TW+2)'(sc);
    cc1_q <= (TW+2)'(cc);
  end

  // M2: triple products and matrix entries, clamped
  logic signed [TW-1:0] m_q [9];
  logic v2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    m_q[0] <= clamp1((TW+3)'(p00_q));
    m_q[1] <= clamp1((TW+3)'(mulr(t_q, cc1_q)) - (TW+3)'(pcs_q));
    m_q[2] <= clamp1((TW+3)'(psc_q) + (TW+3)'(mulr(u_q, cc1_q)));
    m_q[3] <= clamp1((TW+3)'(p10_q));
    m_q[4] <= clamp1((TW+3)'(pcc_q) + (TW+3)'(mulr(t_q, sc1_q)));
    m_q[5] <= clamp1((TW+3)'(mulr(u_q, sc1_q)) - (TW+3)'(psac_q));
    m_q[6] <= clamp1((TW+3)'(nsb_q));
    m_q[7] <= clamp1((TW+3)'(p21_q));
    m_q[8] <= clamp1((TW+3)'(p22_q));
  end

  // vector aligned to M2 output
  logic signed [31:0] v2x_q, v2y_q, v2z_q, v1x_q, v1y_q, v1z_q;
  always_ff @(posedge clk_i) begin
    v1x_q <= vx_q[SL]; v1y_q <= vy_q[SL]; v1z_q <= vz_q[SL];
    v2x_q <= v1x_q;    v2y_q <= v1y_q;    v2z_q <= v1z_q;
  end

  // P1: nine products
  logic signed [AW-1:0] pr_q [9];
  logic v3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else v3_q <= v2_q;
  end
  for (genvar r = 0; r < 3; r++) begin : g_row
    always_ff @(posedge clk_i) begin
      pr_q[3*r+0] <= AW'(m_q[3*r+0]) * AW'(v2x_q);
      pr_q[3*r+1] <= AW'(m_q[3*r+1]) * AW'(v2y_q);
      pr_q[3*r+2] <= AW'(m_q[3*r+2]) * AW'(v2z_q);
    end
  end

  // P2: sum, round, saturate
  logic signed [AW-1:0] acc_w [3];
  logic signed [AW-1:0] rs_w [3];
  logic signed [31:0]   o_w [3];
  logic [2:0]           s_w;
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc_w[r] = pr_q[3*r] + pr_q[3*r+1] + pr_q[3*r+2] + (AW'(1) <<< (F - 1));
      rs_w[r] = acc_w[r] >>> F;
      s_w[r] = 1'b0;
      o_w[r] = 32'(rs_w[r]);
      if (rs_w[r] > AW'(32'sh7FFFFFFF)) begin
        o_w[r] = 32'sh7FFFFFFF; s_w[r] = 1'b1;
      end else if (rs_w[r] < -AW'(33'sh080000000)) begin
        o_w[r] = 32'sh80000000; s_w[r] = 1'b1;
      end
    end
  end
  logic v4_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else v4_q <= v3_q;
  end
  always_ff @(posedge clk_i) begin
    out_x_o <= o_w[0];
    out_y_o <= o_w[1];
    out_z_o <= o_w[2];
    saturated_o <= |s_w;
  end
  assign done_o = v4_q;

  `EAR_ASSERT(a_lanes_agree, clk_i, rst_ni, (vt == vt_y) && (vt == vt_z), "trig lanes out of step")
  `EAR_ASSERT(a_done_follows, clk_i, rst_ni, done_o |-> $past(v3_q), "result without product beat")
  `EAR_ASSERT(a_never_busy, clk_i, rst_ni, !busy, "pipeline stalled")
  `EAR_ASSERT_RST(a_rst_quiet, clk_i, rst_ni, !rst_ni |=> !done_o || rst_ni, "result during reset")
endmodule
`default_nettype wire

@@ tb/tb_euler_angle_rotation_3d.sv @@
// Testbench for euler_angle_rotation_3d: drives vectors and angles, predicts the
// rotated vector and saturation flag per beat, and checks every result strobe.
// Depends on the euler_angle_rotation_3d RTL only.
`default_nettype none
module tb_euler_angle_rotation_3d;

  localparam int Stages    = 18;
  localparam int TrigFrac  = 16;
  localparam int Latency   = Stages + 7;
  localparam int WatchLim  = 2000;
  localparam longint Gain  = 64'sd652032874;
  localparam longint RadQ16 = 64'sd9595049034;

  typedef struct {
    logic signed [31:0] ox, oy, oz;
    logic sat;
  } rot_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] vec_x_i = '0, vec_y_i = '0, vec_z_i = '0;
  logic signed [16:0] angle_x_i = '0, angle_y_i = '0, angle_z_i = '0;
  logic done_o;
  logic signed [31:0] out_x_o, out_y_o, out_z_o;
  logic saturated_o;

  rot_res_t rotated_q[$];
  int errors = 0;
  int beats_in = 0;
  int beats_out = 0;
  int sat_seen = 0;
  int idle_pct = 0;
  int quiet = 0;

  euler_angle_rotation_3d #(.CORDIC_STAGES(Stages), .TRIG_FRAC_BITS(TrigFrac)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .vec_x_i(vec_x_i), .vec_y_i(vec_y_i), .vec_z_i(vec_z_i),
    .angle_x_i(angle_x_i), .angle_y_i(angle_y_i), .angle_z_i(angle_z_i),
    .done_o(done_o), .out_x_o(out_x_o), .out_y_o(out_y_o), .out_z_o(out_z_o),
    .saturated_o(saturated_o)
  );

  always #6 clk_i = ~clk_i;

  // atan(2^-i) in Q30
  function automatic longint atan_tab(int i);
    longint t[31] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
      64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
      64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
      64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
      64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
      64'h00000001};
    return t[i];
  endfunction

  function automatic longint rnd_shr(longint v, int s);
    if (s == 0) return v;
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip_unit(longint v);
    longint one;
    one = 64'sd1 <<< TrigFrac;
    if (v > one) return one;
    if (v < -one) return -one;
    return v;
  endfunction

  function automatic longint fmul(longint a, longint b);
    return rnd_shr(a * b, TrigFrac);
  endfunction

  // Fold angle to [-90,90] with sign flip, then CORDIC sine/cosine
  task automatic trig_of(input logic signed [16:0] ang, output longint s, output longint c);
    longint a, x, y, z, dx, dy;
    bit flip;
    a = ang;
    flip = 0;
    while (a > 23040) a -= 46080;
    while (a < -23040) a += 46080;
    if (a > 11520) begin
      a -= 23040; flip = 1;
    end else if (a < -11520) begin
      a += 23040; flip = 1;
    end
    z = rnd_shr(a * RadQ16, 16);
    x = Gain;
    y = 0;
    for (int i = 0; i < Stages && i < 31; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab(i);
      end else begin
        x += dx; y -= dy; z += atan_tab(i);
      end
    end
    x = clip_unit(rnd_shr(x, 30 - TrigFrac));
    y = clip_unit(rnd_shr(y, 30 - TrigFrac));
    if (flip) begin
      x = -x; y = -y;
    end
    s = y;
    c = x;
  endtask

  task automatic rotate_zyx(input logic signed [31:0] vx, vy, vz,
                            input logic signed [16:0] ax, ay, az, output rot_res_t r);
    longint sa, ca, sb, cb, sc, cc, t, u, acc, o;
    longint m[3][3];
    longint v[3];
    longint res[3];
    trig_of(ax, sa, ca);
    trig_of(ay, sb, cb);
    trig_of(az, sc, cc);
    v[0] = vx; v[1] = vy; v[2] = vz;
    t = fmul(sa, sb);
    u = fmul(ca, sb);
    m[0][0] = fmul(cb, cc);
    m[0][1] = fmul(t, cc) - fmul(ca, sc);
    m[0][2] = fmul(sa, sc) + fmul(u, cc);
    m[1][0] = fmul(cb, sc);
    m[1][1] = fmul(ca, cc) + fmul(t, sc);
    m[1][2] = fmul(u, sc) - fmul(sa, cc);
    m[2][0] = -sb;
    m[2][1] = fmul(sa, cb);
    m[2][2] = fmul(ca, cb);
    r.sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      acc = clip_unit(m[i][0]) * v[0] + clip_unit(m[i][1]) * v[1]
          + clip_unit(m[i][2]) * v[2];
      o = rnd_shr(acc, TrigFrac);
      if (o > 64'sd2147483647) begin
        o = 64'sd2147483647; r.sat = 1'b1;
      end else if (o < -64'sd2147483648) begin
        o = -64'sd2147483648; r.sat = 1'b1;
      end
      res[i] = o;
    end
    r.ox = res[0][31:0];
    r.oy = res[1][31:0];
    r.oz = res[2][31:0];
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH beat %0d %s: got %0d want %0d", beats_out, what, got, want);
    errors++;
  endtask

  // Send one beat; random idle before it per current idle percentage.
  // start stays high after the accepting edge so beats can follow back to back.
  task automatic send_beat(input logic signed [31:0] vx, vy, vz,
                           input logic signed [16:0] ax, ay, az);
    rot_res_t r;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    rotate_zyx(vx, vy, vz, ax, ay, az, r);
    start <= 1'b1;
    vec_x_i <= vx; vec_y_i <= vy; vec_z_i <= vz;
    angle_x_i <= ax; angle_y_i <= ay; angle_z_i <= az;
    do @(posedge clk_i); while (busy);
    rotated_q.push_back(r);
    beats_in++;
  endtask

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      rot_res_t e;
      if (rotated_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        e = rotated_q.pop_front();
        if (out_x_o !== e.ox) report_mismatch("out_x", out_x_o, e.ox);
        if (out_y_o !== e.oy) report_mismatch("out_y", out_y_o, e.oy);
        if (out_z_o !== e.oz) report_mismatch("out_z", out_z_o, e.oz);
        if (saturated_o !== e.sat) report_mismatch("saturated", saturated_o, e.sat);
        if (e.sat) sat_seen++;
      end
      beats_out++;
    end
  end

  // Watchdog on cycles with no accepted beat either way
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || (rotated_q.size() == 0 && !start)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WatchLim) begin
      $display("Watchdog expired");
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic signed [16:0] rand_angle();
    case ($urandom_range(3))
      0: return 17'($urandom);                                  // any pattern
      1: return 17'($signed($urandom_range(92160)) - 46080);    // legal span
      2: return 17'($signed($urandom_range(23040)) - 11520);    // folded-free
      default: return 17'($signed($urandom_range(8) * 5760) - 23040); // octants
    endcase
  endfunction

  function automatic logic signed [31:0] rand_vec();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2000000)) - 1000000);
      2: return $urandom_range(1) ? 32'sh7FFFFFFF - $urandom_range(100)
                                  : 32'sh80000000 + $urandom_range(100);
      default: return 32'($signed($urandom_range(1 << 20)) - (1 << 19)) <<< 8;
    endcase
  endfunction

  task automatic wait_drained();
    start <= 1'b0;
    while (rotated_q.size() != 0) @(posedge clk_i);
  endtask

  // Directed: identity, axis turns, folds, wrap, extremes, saturation
  task automatic test_directed();
    send_beat(32'sh00010000, 32'sh00020000, 32'sh00030000, 0, 0, 0);
    send_beat(32'sh00010000, 0, 0, 17'sd11520, 0, 0);
    send_beat(0, 32'sh00010000, 0, 0, 17'sd11520, 0);
    send_beat(0, 0, 32'sh00010000, 0, 0, 17'sd11520);
    send_beat(32'sh00010000, 32'sh00010000, 32'sh00010000, 17'sd23040, -17'sd23040, 17'sd11521);
    send_beat(32'sh00010000, 32'sh00010000, 32'sh00010000, -17'sd11521, 17'sd46080, -17'sd46080);
    send_beat(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 17'sd5760, 17'sd5760, 17'sd5760);
    send_beat(32'sh80000000, 32'sh80000000, 32'sh80000000, 17'sd5760, 17'sd5760, 17'sd5760);
    send_beat(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, -17'sd5760, 17'sd1, -17'sd1);
    send_beat(32'sh7FFFFFFF, 32'sh80000000, 0, 17'sh0FFFF, 17'sh10000, 17'sh1FFFF);
    send_beat(-32'sd1, 32'sd1, 32'sh55555555, 17'sh0AAAA, 17'sh15555, 17'sd34560);
    send_beat(32'sh12345678, -32'sh12345678, 32'sh0F0F0F0F, 17'sd46079, -17'sd46079, 17'sd128);
    send_beat(0, 0, 0, 17'sh10000, 17'sh0FFFF, 17'sd0);
    // hold off until the pipeline has emptied
    wait_drained();
  endtask

  task automatic test_random(input int n, input int pct);
    idle_pct = pct;
    repeat (n) send_beat(rand_vec(), rand_vec(), rand_vec(), rand_angle(), rand_angle(),
                         rand_angle());
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(200, 17);
    test_random(200, 83);
    wait_drained();
    test_random(200, 0);
    wait_drained();
    repeat (Latency + 5) @(posedge clk_i);
    $display("Covered %0d beats in, %0d results, %0d saturated; idle 17/83/0 pct phases.",
             beats_in, beats_out, sat_seen);
    if (errors == 0 && rotated_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ euler_angle_rotation_3d.f @@
+incdir+rtl
rtl/ear_pkg.sv
rtl/ear_sincos.sv
rtl/euler_angle_rotation_3d.sv
tb/tb_euler_angle_rotation_3d.sv
